[sv/chgw_pkg.sv]
// ----------------------------------------------------------------------------
// chgw_pkg: shared constants for the gift-wrap hull core
// Holds the default sizes that the top level and the cells start from.
// ----------------------------------------------------------------------------
package chgw_pkg;
  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned CoordBitsDef = 16;
endpackage

[sv/chgw_cell.sv]
// ----------------------------------------------------------------------------
// chgw_cell: one storage cell of the point chain
// Holds one point. It compares its point against the value on the broadcast
// bus, and it hands the point it holds to its neighbor when the chain shifts.
// ----------------------------------------------------------------------------
module chgw_cell #(
  parameter int unsigned CoordBits = chgw_pkg::CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic                 clear_i,
  input  logic                 vld_in_i,
  input  logic [CoordBits-1:0] x_in_i,
  input  logic [CoordBits-1:0] y_in_i,
  input  logic [CoordBits-1:0] cmp_x_i,
  input  logic [CoordBits-1:0] cmp_y_i,
  output logic                 vld_o,
  output logic [CoordBits-1:0] x_o,
  output logic [CoordBits-1:0] y_o,
  output logic                 match_o
);
  import chgw_pkg::*;

  logic                 vld_q;
  logic [CoordBits-1:0] x_q, y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (clear_i) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= vld_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q <= x_in_i;
      y_q <= y_in_i;
    end
  end

  assign vld_o   = vld_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign match_o = vld_q && (x_q == cmp_x_i) && (y_q == cmp_y_i);
endmodule

[sv/convex_hull_gift_wrap_core.sv]
// ----------------------------------------------------------------------------
// convex_hull_gift_wrap_core: convex hull of a point set by gift wrapping
// Loads points into a shifting chain of cells, then walks the hull.
// ----------------------------------------------------------------------------
// Usage: points arrive on the input channel (valid_i / stall_o), one word per
// point. A point equal to one already held is ignored; a new point beyond
// MaxPoints is dropped and flagged. Non-final points do not stall the input.
// The word with final_point_i set is taken like the others, and then the hull
// walk starts; the input stalls until every vertex has been passed to the
// output register. The walk finds the pivot in one rotation of the chain. For
// each hull vertex it then rotates the chain once more, testing one candidate
// at a time with a cross product split over two pipeline stages, and emits
// the vertex once its successor is known. Vertices leave on the output
// channel (valid_o / stall_i) through an output register; a stalled receiver
// simply holds the walk.
// Reset clears the chain valid bits, the count and the overflow flag.
// ----------------------------------------------------------------------------
module convex_hull_gift_wrap_core #(
  parameter int unsigned MaxPoints = chgw_pkg::MaxPointsDef,
  parameter int unsigned CoordBits = chgw_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic signed [CoordBits-1:0] point_x_i,
  input  logic signed [CoordBits-1:0] point_y_i,
  input  logic                        final_point_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic signed [CoordBits-1:0] vertex_x_o,
  output logic signed [CoordBits-1:0] vertex_y_o,
  output logic                        last_vertex_o,
  output logic                        points_dropped_o
);
  import chgw_pkg::*;

  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned DW   = CoordBits + 1;
  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned SW   = 2 * PW + 1;

  typedef enum logic [4:0] {
    StLoad  = 5'b00001,
    StPivot = 5'b00010,
    StScan  = 5'b00100,
    StEmit  = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Chain wiring: cell 0 is the head; during a rotation the head point wraps
  // back into the tail so the set is preserved.
  logic                 c_vld [MaxPoints];
  logic [CoordBits-1:0] c_x   [MaxPoints];
  logic [CoordBits-1:0] c_y   [MaxPoints];
  logic                 c_m   [MaxPoints];
  logic                 n_vld [MaxPoints];
  logic [CoordBits-1:0] n_x   [MaxPoints];
  logic [CoordBits-1:0] n_y   [MaxPoints];
  logic                 load, clear, any_match;

  logic [CntW-1:0] count_q;
  logic            ovf_q;
  logic            accept;
  logic            is_new;
  logic            rot;

  assign accept = valid_i && !stall_o;

  always_comb begin
    any_match = 1'b0;
    for (int i = 0; i < MaxPoints; i++) any_match |= c_m[i];
  end
  assign is_new = !any_match && (count_q < CntW'(MaxPoints));

  // Loading pushes at the slot count_q; other cells keep their contents.
  // Rotation shifts each cell toward the head, the head wraps to slot count_q - 1.
  genvar g;
  generate
    for (g = 0; g < MaxPoints; g++) begin : g_cell
      always_comb begin
        if (rot) begin
          if (CntW'(g) == count_q - CntW'(1)) begin
            n_vld[g] = c_vld[0];
            n_x[g]   = c_x[0];
            n_y[g]   = c_y[0];
          end else if (g + 1 < MaxPoints) begin
            n_vld[g] = c_vld[(g + 1) % MaxPoints];
            n_x[g]   = c_x[(g + 1) % MaxPoints];
            n_y[g]   = c_y[(g + 1) % MaxPoints];
          end else begin
            n_vld[g] = c_vld[g];
            n_x[g]   = c_x[g];
            n_y[g]   = c_y[g];
          end
        end else if (CntW'(g) == count_q && accept && is_new) begin
          n_vld[g] = 1'b1;
          n_x[g]   = point_x_i;
          n_y[g]   = point_y_i;
        end else begin
          n_vld[g] = c_vld[g];
          n_x[g]   = c_x[g];
          n_y[g]   = c_y[g];
        end
      end
      chgw_cell #(.CoordBits(CoordBits)) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .load_i   (load),
        .clear_i  (clear),
        .vld_in_i (n_vld[g]),
        .x_in_i   (n_x[g]),
        .y_in_i   (n_y[g]),
        .cmp_x_i  (point_x_i),
        .cmp_y_i  (point_y_i),
        .vld_o    (c_vld[g]),
        .x_o      (c_x[g]),
        .y_o      (c_y[g]),
        .match_o  (c_m[g])
      );
    end
  endgenerate

  // Walk registers.
  logic [CntW-1:0]             step_q;
  logic                        ph_q;         // set in the compare phase of a candidate test
  logic signed [CoordBits-1:0] px_q, py_q;   // pivot
  logic signed [CoordBits-1:0] ox_q, oy_q;   // current vertex
  logic signed [CoordBits-1:0] bx_q, by_q;   // best candidate
  logic                        bv_q;         // candidate chosen yet
  logic                        is_last;
  logic                        emit;
  // Pipeline stage: products of the head point against the current best.
  logic                        s1v_q;
  logic signed [CoordBits-1:0] s1x_q, s1y_q;
  logic signed [PW-1:0]        p1_q, p2_q, d1_q, d2_q, e1_q, e2_q;
  logic signed [DW-1:0]        ax, ay, bx, by;
  logic signed [SW-1:0]        crs, dnew, dbest;
  logic                        take;

  logic signed [CoordBits-1:0] hx, hy;
  assign hx = c_x[0];
  assign hy = c_y[0];

  assign ax = DW'(bx_q) - DW'(ox_q);
  assign ay = DW'(by_q) - DW'(oy_q);
  assign bx = DW'(hx) - DW'(ox_q);
  assign by = DW'(hy) - DW'(oy_q);

  assign crs   = SW'(p1_q) - SW'(p2_q);
  assign dnew  = SW'(d1_q) + SW'(d2_q);
  assign dbest = SW'(e1_q) + SW'(e2_q);

  // Stage-two candidate test; the head equal to the vertex is skipped. A new
  // candidate enters only once the previous test is done, so stage one always
  // sees the best point that the previous test settled on.
  logic same_o;
  logic s1same_q;
  assign same_o = (hx == ox_q) && (hy == oy_q);
  assign take = s1v_q && !s1same_q &&
                (!bv_q || crs < 0 || (crs == 0 && dnew > dbest));

  // The current vertex is the last one when no other point exists or when
  // its successor is the pivot again.
  assign is_last = !bv_q || (bx_q == px_q && by_q == py_q);

  logic                        ov_q, olast_q;
  logic signed [CoordBits-1:0] ovx_q, ovy_q;
  logic                        odrop_q;
  logic                        out_free;
  assign out_free = !ov_q || !stall_i;
  assign emit     = (state_q == StEmit) && out_free;

  logic scan_feed;
  assign scan_feed = (state_q == StScan) && !ph_q && (step_q < count_q);
  assign rot   = (state_q == StPivot && step_q < count_q) || scan_feed;
  assign load  = rot || (accept && state_q == StLoad);
  assign clear = (state_q == StDone);

  assign stall_o = (state_q != StLoad);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StLoad:  if (accept && final_point_i) state_d = StPivot;
      StPivot: if (step_q == count_q) state_d = (count_q == '0) ? StDone : StScan;
      StScan:  if (ph_q && step_q == count_q) state_d = StEmit;
      StEmit:  if (out_free) state_d = is_last ? StDone : StScan;
      StDone:  state_d = StLoad;
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      count_q <= '0;
      ovf_q   <= 1'b0;
      step_q  <= '0;
      ph_q    <= 1'b0;
      s1v_q   <= 1'b0;
      ov_q    <= 1'b0;
      bv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (!stall_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        StLoad: begin
          step_q <= '0;
          if (accept) begin
            if (is_new) count_q <= count_q + CntW'(1);
            else if (!any_match) ovf_q <= 1'b1;
          end
        end
        StPivot: begin
          bv_q  <= 1'b0;
          s1v_q <= 1'b0;
          ph_q  <= 1'b0;
          if (step_q == count_q) step_q <= '0;
          else step_q <= step_q + CntW'(1);
        end
        StScan: begin
          ph_q  <= !ph_q;
          s1v_q <= scan_feed;
          if (scan_feed) step_q <= step_q + CntW'(1);
          if (take) bv_q <= 1'b1;
        end
        StEmit: begin
          if (out_free) begin
            step_q <= '0;
            bv_q   <= 1'b0;
            s1v_q  <= 1'b0;
            ph_q   <= 1'b0;
          end
        end
        StDone: begin
          count_q <= '0;
          ovf_q   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StPivot: begin
        if (step_q < count_q &&
            (step_q == '0 || hx < px_q || (hx == px_q && hy < py_q))) begin
          px_q <= hx;
          py_q <= hy;
        end
        if (step_q == count_q) begin
          ox_q <= px_q;
          oy_q <= py_q;
        end
      end
      StScan: begin
        if (scan_feed) begin
          s1x_q    <= hx;
          s1y_q    <= hy;
          s1same_q <= same_o;
          p1_q <= PW'(ax * by);
          p2_q <= PW'(ay * bx);
          d1_q <= PW'(bx * bx);
          d2_q <= PW'(by * by);
          e1_q <= PW'(ax * ax);
          e2_q <= PW'(ay * ay);
        end
        if (take) begin
          bx_q <= s1x_q;
          by_q <= s1y_q;
        end
      end
      StEmit: begin
        if (out_free) begin
          ovx_q   <= ox_q;
          ovy_q   <= oy_q;
          odrop_q <= ovf_q;
          olast_q <= is_last;
          ox_q    <= bx_q;
          oy_q    <= by_q;
        end
      end
      default: ;
    endcase
  end

  assign valid_o          = ov_q;
  assign vertex_x_o       = ovx_q;
  assign vertex_y_o       = ovy_q;
  assign last_vertex_o    = olast_q;
  assign points_dropped_o = odrop_q;
endmodule

[bench/convex_hull_gift_wrap_core_tb.sv]
// ----------------------------------------------------------------------------
// convex_hull_gift_wrap_core_tb: self-checking bench for the gift-wrap core
// Sends point sets one word at a time and predicts each hull in the bench.
// Every vertex word is checked field by field against the oldest prediction.
// Runs directed shapes, a capacity overflow and random sets under four idling
// phases.
// ----------------------------------------------------------------------------
module convex_hull_gift_wrap_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap       = chgw_pkg::MaxPointsDef;
  localparam int unsigned Cb        = chgw_pkg::CoordBitsDef;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned RandomItems = 200;

  typedef logic signed [Cb-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
    logic   dropped;
  } vertex_t;

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   valid_i, stall_o, final_point_i;
  coord_t point_x_i, point_y_i;
  logic   valid_o, stall_i;
  coord_t vertex_x_o, vertex_y_o;
  logic   last_vertex_o, points_dropped_o;

  convex_hull_gift_wrap_core dut (
    .clk_i, .rst_ni, .valid_i, .stall_o, .point_x_i, .point_y_i, .final_point_i,
    .valid_o, .stall_i, .vertex_x_o, .vertex_y_o, .last_vertex_o, .points_dropped_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bench copy of the point store, filled as words are accepted.
  int          held_x [Cap];
  int          held_y [Cap];
  int unsigned held_count;
  bit          overflow_flag;
  vertex_t     hull_q[$];

  int unsigned errors;
  int unsigned sent_items;
  int unsigned send_idle_pct, recv_stall_pct;
  longint unsigned cycles;

  function automatic longint cross_at(int o, int a, int b);
    longint ax, ay, bx, by;
    ax = longint'(held_x[a]) - held_x[o];
    ay = longint'(held_y[a]) - held_y[o];
    bx = longint'(held_x[b]) - held_x[o];
    by = longint'(held_y[b]) - held_y[o];
    return ax * by - ay * bx;
  endfunction

  function automatic longint span2(int o, int a);
    longint dx, dy;
    dx = longint'(held_x[a]) - held_x[o];
    dy = longint'(held_y[a]) - held_y[o];
    return dx * dx + dy * dy;
  endfunction

  // Jarvis march over the held points; pushes one expected word per vertex.
  function automatic void predict_hull();
    int n, pivot, cur, cand, h;
    int hull_idx[$];
    vertex_t v;
    longint c;
    n = held_count;
    pivot = 0;
    for (int i = 1; i < n; i++)
      if (held_x[i] < held_x[pivot] ||
          (held_x[i] == held_x[pivot] && held_y[i] < held_y[pivot]))
        pivot = i;
    cur = pivot;
    h = 0;
    while (h < n) begin
      cand = (cur == 0) ? 1 : 0;
      hull_idx.push_back(cur);
      h++;
      if (n < 2) break;
      for (int i = 0; i < n; i++) begin
        if (i == cur || i == cand) continue;
        c = cross_at(cur, cand, i);
        // Ties on the line go to the farther point, so edge points drop out.
        if (c < 0 || (c == 0 && span2(cur, i) > span2(cur, cand))) cand = i;
      end
      if (cand == pivot) break;
      cur = cand;
    end
    foreach (hull_idx[k]) begin
      v.x       = coord_t'(held_x[hull_idx[k]]);
      v.y       = coord_t'(held_y[hull_idx[k]]);
      v.last    = (k == hull_idx.size() - 1);
      v.dropped = overflow_flag;
      hull_q.push_back(v);
    end
    held_count    = 0;
    overflow_flag = 1'b0;
  endfunction

  function automatic void accept_point(int x, int y, bit fin);
    bit dup;
    dup = 1'b0;
    for (int i = 0; i < held_count; i++)
      if (held_x[i] == x && held_y[i] == y) dup = 1'b1;
    if (!dup) begin
      if (held_count < Cap) begin
        held_x[held_count] = x;
        held_y[held_count] = y;
        held_count++;
      end else begin
        overflow_flag = 1'b1;
      end
    end
    if (fin) predict_hull();
  endfunction

  // Sends one point word, idling first at the current rate.
  task automatic send_point(int x, int y, bit fin);
    if ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    valid_i       <= 1'b1;
    point_x_i     <= coord_t'(x);
    point_y_i     <= coord_t'(y);
    final_point_i <= fin;
    do @(posedge clk_i); while (stall_o);
    accept_point(x, y, fin);
    sent_items++;
  endtask

  // Holds the sender off until every predicted vertex has come back.
  task automatic drain();
    valid_i <= 1'b0;
    while (hull_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // The receiver checks each accepted vertex word and picks its next stall.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (hull_q.size() == 0) begin
        $display("%0t: unexpected vertex x=%0d y=%0d", $time, vertex_x_o, vertex_y_o);
        errors++;
      end else begin
        vertex_t e;
        e = hull_q.pop_front();
        if (vertex_x_o !== e.x) begin
          $display("%0t: vertex_x expected %0d actual %0d", $time, e.x, vertex_x_o);
          errors++;
        end
        if (vertex_y_o !== e.y) begin
          $display("%0t: vertex_y expected %0d actual %0d", $time, e.y, vertex_y_o);
          errors++;
        end
        if (last_vertex_o !== e.last) begin
          $display("%0t: last_vertex expected %0b actual %0b", $time, e.last,
                   last_vertex_o);
          errors++;
        end
        if (points_dropped_o !== e.dropped) begin
          $display("%0t: points_dropped expected %0b actual %0b", $time, e.dropped,
                   points_dropped_o);
          errors++;
        end
      end
    end
    stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("convex_hull_gift_wrap_core_tb failed");
      $finish;
    end
  end

  function automatic int rand_coord(int mode);
    case (mode)
      0:       return $urandom_range(8) - 4;
      1:       return $urandom_range(1) ? 32767 - $urandom_range(3) : -32768 + $urandom_range(3);
      default: return int'(coord_t'($urandom));
    endcase
  endfunction

  task automatic test_single_points();
    send_point(-32768, 32767, 1'b1);
    send_point(32767, -32768, 1'b1);
    // Repeats of one point still give a single vertex.
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b1);
  endtask

  task automatic test_two_and_collinear();
    send_point(32767, 32767, 1'b0);
    send_point(-32768, -32768, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(3, 3, 1'b0);
    send_point(1, 1, 1'b0);
    send_point(-2, -2, 1'b1);
  endtask

  task automatic test_square_with_inside();
    send_point(0, 0, 1'b0);
    send_point(10, 0, 1'b0);
    send_point(5, 5, 1'b0);
    send_point(10, 10, 1'b0);
    send_point(5, 0, 1'b0);
    send_point(0, 10, 1'b0);
    send_point(0, 5, 1'b0);
    // Tie on least x: the lower point is the pivot.
    send_point(-32768, 32767, 1'b0);
    send_point(-32768, -32768, 1'b1);
  endtask

  // More distinct points than the store holds, the final one dropped too.
  task automatic test_capacity();
    for (int i = 0; i < Cap + 3; i++)
      send_point(i * 97 - 3000, (i * i * 31) % 2000 - 1000, i == Cap + 2);
    drain();
  endtask

  task automatic test_random_sets(int unsigned idle_pct, int unsigned stall_pct,
                                  int unsigned quota);
    int unsigned start, n, mode;
    start = sent_items;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent_items - start < quota) begin
      n = $urandom_range(19);
      n = (n < 16) ? $urandom_range(12, 1) : (n < 19) ? $urandom_range(40, 13)
                                                       : $urandom_range(70, 60);
      mode = $urandom_range(2);
      for (int i = 0; i < n; i++)
        send_point(rand_coord(mode), rand_coord(mode), i == n - 1);
    end
    drain();
  endtask

  initial begin
    rst_ni         = 1'b0;
    valid_i       <= 1'b0;
    point_x_i     <= '0;
    point_y_i     <= '0;
    final_point_i <= 1'b0;
    held_count     = 0;
    overflow_flag  = 1'b0;
    sent_items     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_points();
    test_two_and_collinear();
    test_square_with_inside();
    drain();
    test_capacity();
    test_random_sets(0, 0, RandomItems / 4);
    test_random_sets(67, 0, RandomItems / 4);
    test_random_sets(0, 67, RandomItems / 4);
    test_random_sets(18, 18, RandomItems / 4);

    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("convex_hull_gift_wrap_core_tb passed");
    end else begin
      $display("convex_hull_gift_wrap_core_tb failed");
    end
    $finish;
  end
endmodule
